@@ design/pfps_pkg.sv @@
// Package for the force point particle step block.
// Shared types, reset values, register indexes and the saturation helper.
package pfps_pkg;

   localparam int MAX_POINTS_DEF = 64;
   localparam int WORD_W         = 32;
   localparam int STEP_W         = 17;
   localparam int COUNT_W        = 7;
   localparam int SAT_W          = 54;

   localparam logic [STEP_W-1:0] TIME_STEP_RST = 17'd1092;
   localparam logic [4:0]        GRAVITY_RAW   = 5'd10;

   typedef enum logic {
      CSR_ACTIVE_POINTS = 1'b0,
      CSR_TIME_STEP     = 1'b1
   } csr_index_type;

   typedef enum logic {
      OP_WRITE_POINT = 1'b0,
      OP_STEP        = 1'b1
   } opcode_type;

   typedef struct packed {
      logic signed [WORD_W-1:0] x;
      logic signed [WORD_W-1:0] y;
   } point_type;

   function automatic logic signed [WORD_W-1:0] sat32(input logic signed [SAT_W-1:0] v);
      logic signed [SAT_W-1:0] hi;
      logic signed [SAT_W-1:0] lo;
      hi = SAT_W'(64'sd2147483647);
      lo = -SAT_W'(64'sd2147483648);
      if (v > hi) begin
         sat32 = 32'sh7fffffff;
      end else if (v < lo) begin
         sat32 = 32'sh80000000;
      end else begin
         sat32 = v[WORD_W-1:0];
      end
   endfunction

endpackage

@@ design/pfps_table.sv @@
// Force point table: one write port, one read port with registered data.
// Depends on pfps_pkg for the point type.
module pfps_table
   import pfps_pkg::*;
#(
   parameter int MAX_POINTS = MAX_POINTS_DEF,
   parameter int AW         = 6
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  point_type     wr_data,
   input  logic [AW-1:0] rd_addr,
   output point_type     rd_data
);

   point_type mem [MAX_POINTS];
   point_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ design/particle_force_point_step.sv @@
// Top level of the force point particle step: sequencer, shared multiplier and divider.
// Depends on pfps_pkg and pfps_table.
//
//  channel | ports                        | direction
//  req     | req_valid/req_ready + fields | in: point write or particle word
//  rsp     | rsp_valid/rsp_ready + fields | out: stepped particle word
//  csr     | csr_we/csr_index/csr_wdata   | in: register writes
//
// A point write goes straight to the table. A particle visits each active point in
// turn: two 31-step restoring divisions share one subtractor per point, and one
// 34x34 multiplier serves the squares and the position moves. A point at zero
// distance skips both divisions and a saturated term skips its division.
// Reset is synchronous; the table is not cleared. The finished word waits in
// the output register and a new word is taken meanwhile; the last step of the
// next particle holds while that register is still full.
module particle_force_point_step
   import pfps_pkg::*;
#(
   parameter int MAX_POINTS = MAX_POINTS_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic                     req_opcode,
   input  logic [5:0]               req_point_index,
   input  logic signed [WORD_W-1:0] req_pos_x,
   input  logic signed [WORD_W-1:0] req_pos_y,
   input  logic signed [WORD_W-1:0] req_vel_x,
   input  logic signed [WORD_W-1:0] req_vel_y,
   input  logic signed [WORD_W-1:0] req_life_left,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic signed [WORD_W-1:0] rsp_new_pos_x,
   output logic signed [WORD_W-1:0] rsp_new_pos_y,
   output logic signed [WORD_W-1:0] rsp_new_vel_x,
   output logic signed [WORD_W-1:0] rsp_new_vel_y,
   output logic signed [WORD_W-1:0] rsp_new_life,
   output logic                     rsp_alive,
   input  logic                     csr_we,
   input  logic                     csr_index,
   input  logic [STEP_W-1:0]        csr_wdata
);

   localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
   localparam int CW = (AW + 1 > COUNT_W) ? AW + 1 : COUNT_W;

   typedef enum logic [3:0] {
      ST_IDLE, ST_FETCH, ST_DIFF, ST_SQX, ST_SQY, ST_DSET, ST_DIV, ST_DADD,
      ST_GRAV, ST_MULX, ST_MOVX, ST_MOVY
   } state_type;

   state_type                state_ff;
   logic [COUNT_W-1:0]       active_ff;
   logic [STEP_W-1:0]        step_ff;
   logic [STEP_W-1:0]        dt_ff;
   logic [CW-1:0]            n_ff;
   logic [CW-1:0]            i_ff;
   logic signed [WORD_W-1:0] px_ff, py_ff, vx_ff, vy_ff, life_ff;
   logic signed [32:0]       dx_ff, dy_ff;
   logic [65:0]              s_ff;
   logic [66:0]              rem_ff;
   logic [30:0]              q_ff;
   logic [4:0]               cnt_ff;
   logic                     axis_ff;
   logic                     sat_ff;
   logic signed [67:0]       prod_ff;
   logic                     rsp_valid_ff;
   logic signed [WORD_W-1:0] o_px_ff, o_py_ff, o_vx_ff, o_vy_ff, o_life_ff;
   logic                     o_alive_ff;

   point_type          rd_point;
   point_type          wr_point;
   logic               wr_en;
   logic [CW-1:0]      idx_ext;
   logic [CW-1:0]      act_ext;
   logic [CW-1:0]      n_new;
   logic [CW-1:0]      i_next;
   logic               accept;
   logic signed [33:0] mul_a, mul_b;
   logic signed [67:0] prod;
   logic [32:0]        mag_x, mag_y, mag;
   logic               neg;
   logic [66:0]        r2;
   logic signed [32:0] term;
   logic signed [33:0] vsum;
   logic signed [67:0] qmove;
   logic [20:0]        grav;
   logic               out_free;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign idx_ext   = CW'(req_point_index);
   assign act_ext   = CW'(active_ff);
   assign n_new     = (act_ext > CW'(MAX_POINTS)) ? CW'(MAX_POINTS) : act_ext;
   assign i_next    = i_ff + CW'(1);
   assign wr_en     = accept && (req_opcode == OP_WRITE_POINT) && (idx_ext < CW'(MAX_POINTS));
   assign wr_point  = '{x: req_pos_x, y: req_pos_y};
   assign out_free  = !rsp_valid_ff || rsp_ready;

   pfps_table #(
      .MAX_POINTS(MAX_POINTS),
      .AW        (AW)
   ) u_table (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(idx_ext[AW-1:0]),
      .wr_data(wr_point),
      .rd_addr(i_ff[AW-1:0]),
      .rd_data(rd_point)
   );

   assign mag_x = dx_ff[32] ? 33'(-dx_ff) : 33'(dx_ff);
   assign mag_y = dy_ff[32] ? 33'(-dy_ff) : 33'(dy_ff);
   assign mag   = axis_ff ? mag_y : mag_x;
   assign neg   = axis_ff ? dy_ff[32] : dx_ff[32];
   assign r2    = {rem_ff[65:0], 1'b0};
   assign grav  = 21'({dt_ff, 3'b000}) + 21'({dt_ff, 1'b0});

   always_comb begin
      unique case (state_ff)
         ST_SQX: begin
            mul_a = $signed({1'b0, mag_x});
            mul_b = $signed({1'b0, mag_x});
         end
         ST_SQY: begin
            mul_a = $signed({1'b0, mag_y});
            mul_b = $signed({1'b0, mag_y});
         end
         ST_MULX: begin
            mul_a = 34'(vx_ff);
            mul_b = $signed({17'b0, dt_ff});
         end
         default: begin
            mul_a = 34'(vy_ff);
            mul_b = $signed({17'b0, dt_ff});
         end
      endcase
   end

   assign prod = mul_a * mul_b;

   always_comb begin
      if (sat_ff) begin
         term = neg ? -33'sd2147483648 : 33'sd2147483647;
      end else begin
         term = neg ? -$signed({2'b00, q_ff}) : $signed({2'b00, q_ff});
      end
      vsum = (axis_ff ? 34'(vy_ff) : 34'(vx_ff)) + 34'(term);
      if (prod_ff < 0 && prod_ff[15:0] != 16'd0) begin
         qmove = (prod_ff >>> 16) + 68'sd1;
      end else begin
         qmove = prod_ff >>> 16;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         active_ff    <= '0;
         step_ff      <= TIME_STEP_RST;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            unique case (csr_index_type'(csr_index))
               CSR_ACTIVE_POINTS: active_ff <= csr_wdata[COUNT_W-1:0];
               CSR_TIME_STEP:     step_ff   <= csr_wdata;
            endcase
         end
         if (rsp_valid_ff && rsp_ready && state_ff != ST_MOVY) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (accept && req_opcode == OP_STEP) begin
                  px_ff   <= req_pos_x;
                  py_ff   <= req_pos_y;
                  vx_ff   <= req_vel_x;
                  vy_ff   <= req_vel_y;
                  life_ff <= req_life_left;
                  dt_ff   <= step_ff;
                  n_ff    <= n_new;
                  i_ff    <= '0;
                  state_ff <= (n_new == '0) ? ST_GRAV : ST_FETCH;
               end
            end
            ST_FETCH: state_ff <= ST_DIFF;
            ST_DIFF: begin
               dx_ff    <= 33'(px_ff) - 33'(rd_point.x);
               dy_ff    <= 33'(py_ff) - 33'(rd_point.y);
               state_ff <= ST_SQX;
            end
            ST_SQX: begin
               s_ff     <= prod[65:0];
               state_ff <= ST_SQY;
            end
            ST_SQY: begin
               s_ff     <= s_ff + prod[65:0];
               axis_ff  <= 1'b0;
               state_ff <= ST_DSET;
            end
            ST_DSET: begin
               if (s_ff == '0) begin
                  i_ff     <= i_next;
                  state_ff <= (i_next == n_ff) ? ST_GRAV : ST_FETCH;
               end else if (66'({mag, 1'b0}) >= s_ff) begin
                  sat_ff   <= 1'b1;
                  state_ff <= ST_DADD;
               end else begin
                  sat_ff   <= 1'b0;
                  rem_ff   <= 67'({mag, 1'b0});
                  q_ff     <= '0;
                  cnt_ff   <= 5'd30;
                  state_ff <= ST_DIV;
               end
            end
            ST_DIV: begin
               if (r2 >= {1'b0, s_ff}) begin
                  rem_ff <= r2 - {1'b0, s_ff};
                  q_ff   <= {q_ff[29:0], 1'b1};
               end else begin
                  rem_ff <= r2;
                  q_ff   <= {q_ff[29:0], 1'b0};
               end
               cnt_ff <= cnt_ff - 5'd1;
               if (cnt_ff == 5'd0) begin
                  state_ff <= ST_DADD;
               end
            end
            ST_DADD: begin
               if (axis_ff) begin
                  vy_ff    <= sat32(SAT_W'(vsum));
                  i_ff     <= i_next;
                  state_ff <= (i_next == n_ff) ? ST_GRAV : ST_FETCH;
               end else begin
                  vx_ff    <= sat32(SAT_W'(vsum));
                  axis_ff  <= 1'b1;
                  state_ff <= ST_DSET;
               end
            end
            ST_GRAV: begin
               vy_ff    <= sat32(SAT_W'(vy_ff) - SAT_W'($signed({1'b0, grav})));
               state_ff <= ST_MULX;
            end
            ST_MULX: begin
               prod_ff  <= prod;
               state_ff <= ST_MOVX;
            end
            ST_MOVX: begin
               px_ff    <= sat32(SAT_W'(px_ff) + SAT_W'(qmove));
               prod_ff  <= prod;
               state_ff <= ST_MOVY;
            end
            ST_MOVY: begin
               if (out_free) begin
                  o_px_ff      <= px_ff;
                  o_py_ff      <= sat32(SAT_W'(py_ff) + SAT_W'(qmove));
                  o_vx_ff      <= vx_ff;
                  o_vy_ff      <= vy_ff;
                  o_life_ff    <= sat32(SAT_W'(life_ff) - SAT_W'($signed({1'b0, dt_ff})));
                  o_alive_ff   <= (SAT_W'(life_ff) - SAT_W'($signed({1'b0, dt_ff}))) > 0;
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_new_pos_x = o_px_ff;
   assign rsp_new_pos_y = o_py_ff;
   assign rsp_new_vel_x = o_vx_ff;
   assign rsp_new_vel_y = o_vy_ff;
   assign rsp_new_life  = o_life_ff;
   assign rsp_alive     = o_alive_ff;

endmodule

@@ dv/particle_force_point_step_test.sv @@
// Testbench for particle_force_point_step: a directed table, then random phases of point
// writes and particle words, checked against typed rows or an in-bench fixed point predictor.
// Depends on pfps_pkg and the particle_force_point_step RTL.
module particle_force_point_step_test;
   import pfps_pkg::*;

   typedef struct {
      opcode_type        op;
      logic [5:0]        idx;
      logic signed [31:0] px, py, vx, vy, life;
   } req_word_type;

   typedef struct {
      logic signed [31:0] px, py, vx, vy, life;
      logic               alive;
   } step_out_type;

   typedef struct {
      bit            is_csr;
      csr_index_type ci;
      logic [16:0]   cv;
      req_word_type  w;
      bit            typed;
      step_out_type  res;
   } row_type;

   localparam longint SMAX = 64'sd2147483647;
   localparam longint SMIN = -64'sd2147483648;
   localparam int     LIMIT = 3000000;

   logic clock, reset;
   logic req_valid, req_ready, req_opcode;
   logic [5:0] req_point_index;
   logic signed [31:0] req_pos_x, req_pos_y, req_vel_x, req_vel_y, req_life_left;
   logic rsp_valid, rsp_ready, rsp_alive;
   logic signed [31:0] rsp_new_pos_x, rsp_new_pos_y, rsp_new_vel_x, rsp_new_vel_y;
   logic signed [31:0] rsp_new_life;
   logic csr_we, csr_index;
   logic [STEP_W-1:0] csr_wdata;

   particle_force_point_step dut (.*);

   longint       pt_x[64], pt_y[64];
   int           n_active;
   longint       step_dt;
   step_out_type pending[$];
   row_type      rows[$];
   int           mismatches, cycles, n_checked;
   bit           steady, stimulus_done;

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   function automatic longint clip(longint v);
      return v > SMAX ? SMAX : (v < SMIN ? SMIN : v);
   endfunction

   function automatic longint force_term(longint d, logic [127:0] s);
      logic [127:0] q;
      q = (128'(d < 0 ? -d : d) << 32) / s;
      if (q >= 128'h8000_0000) return d < 0 ? SMIN : SMAX;
      return d < 0 ? -longint'(q) : longint'(q);
   endfunction

   function automatic step_out_type step_particle(req_word_type w);
      longint dx, dy, vx, vy, life;
      logic [127:0] s;
      int n;
      step_out_type r;
      vx = w.vx;
      vy = w.vy;
      n = n_active > 64 ? 64 : n_active;
      for (int i = 0; i < n; i++) begin
         dx = longint'(w.px) - pt_x[i];
         dy = longint'(w.py) - pt_y[i];
         s = 128'(dx < 0 ? -dx : dx) * 128'(dx < 0 ? -dx : dx)
           + 128'(dy < 0 ? -dy : dy) * 128'(dy < 0 ? -dy : dy);
         if (s == 0) continue;
         vx = clip(vx + force_term(dx, s));
         vy = clip(vy + force_term(dy, s));
      end
      vy = clip(vy - 10 * step_dt);
      life = clip(longint'(w.life) - step_dt);
      r.px = 32'(clip(longint'(w.px) + (vx * step_dt) / 65536));
      r.py = 32'(clip(longint'(w.py) + (vy * step_dt) / 65536));
      r.vx = 32'(vx);
      r.vy = 32'(vy);
      r.life = 32'(life);
      r.alive = life > 0;
      return r;
   endfunction

   function automatic req_word_type point_word(int i, longint x, longint y);
      req_word_type w;
      w.op = OP_WRITE_POINT;
      w.idx = 6'(i);
      w.px = 32'(x);
      w.py = 32'(y);
      w.vx = $urandom;
      w.vy = $urandom;
      w.life = $urandom;
      return w;
   endfunction

   function automatic req_word_type particle(longint x, longint y, longint vx, longint vy,
                                             longint life);
      req_word_type w;
      w.op = OP_STEP;
      w.idx = 6'($urandom);
      w.px = 32'(x);
      w.py = 32'(y);
      w.vx = 32'(vx);
      w.vy = 32'(vy);
      w.life = 32'(life);
      return w;
   endfunction

   function automatic void add_word(req_word_type w);
      row_type r;
      r.is_csr = 0;
      r.w = w;
      r.typed = 0;
      rows.push_back(r);
   endfunction

   function automatic void add_typed(req_word_type w, longint px, longint py, longint vx,
                                     longint vy, longint life, bit alive);
      row_type r;
      r.is_csr = 0;
      r.w = w;
      r.typed = 1;
      r.res = '{32'(px), 32'(py), 32'(vx), 32'(vy), 32'(life), alive};
      rows.push_back(r);
   endfunction

   function automatic void add_csr(csr_index_type ci, logic [16:0] v);
      row_type r;
      r.is_csr = 1;
      r.ci = ci;
      r.cv = v;
      rows.push_back(r);
   endfunction

   task automatic send_word(req_word_type w, bit typed, step_out_type res);
      while (!steady && $urandom_range(99) < 36) begin
         req_valid = 0;
         @(negedge clock);
      end
      req_valid = 1;
      req_opcode = w.op;
      req_point_index = w.idx;
      req_pos_x = w.px;
      req_pos_y = w.py;
      req_vel_x = w.vx;
      req_vel_y = w.vy;
      req_life_left = w.life;
      do @(posedge clock); while (!req_ready);
      if (w.op == OP_WRITE_POINT) begin
         pt_x[w.idx] = w.px;
         pt_y[w.idx] = w.py;
      end else begin
         pending.push_back(typed ? res : step_particle(w));
      end
      @(negedge clock);
      req_valid = 0;
   endtask

   task automatic write_reg(csr_index_type ci, logic [16:0] v);
      while (pending.size() != 0) @(negedge clock);
      repeat (100) @(negedge clock);
      csr_we = 1;
      csr_index = ci;
      csr_wdata = v;
      @(negedge clock);
      csr_we = 0;
      if (ci == CSR_ACTIVE_POINTS) n_active = v[6:0];
      else step_dt = v;
   endtask

   function automatic req_word_type random_word();
      int k, mode;
      longint x, y;
      if ($urandom_range(99) < 15) begin
         k = $urandom_range(63);
         if ($urandom_range(1)) return point_word(k, $signed($urandom), $signed($urandom));
         return point_word(k, $signed(32'($urandom_range(400000))) - 200000,
                           $signed(32'($urandom_range(400000))) - 200000);
      end
      k = n_active == 0 ? 0 : $urandom_range((n_active > 64 ? 64 : n_active) - 1);
      mode = $urandom_range(3);
      x = mode == 3 ? longint'($signed($urandom)) : pt_x[k];
      y = mode == 3 ? longint'($signed($urandom)) : pt_y[k];
      if (mode == 1 || mode == 2) begin
         x = clip(x + longint'($urandom_range(mode == 1 ? 8 : 400000)) - (mode == 1 ? 4 : 200000));
         y = clip(y + longint'($urandom_range(mode == 1 ? 8 : 400000)) - (mode == 1 ? 4 : 200000));
      end
      if ($urandom_range(1))
         return particle(x, y, $signed($urandom), $signed($urandom), $signed($urandom));
      return particle(x, y, longint'($urandom_range(2000000)) - 1000000,
                      longint'($urandom_range(2000000)) - 1000000,
                      longint'($urandom_range(400000)) - 20000);
   endfunction

   function automatic bit differs(string f, logic [31:0] e, logic [31:0] a);
      if (e === a) return 0;
      if (mismatches < 10) $display("mismatch %s: expected %h actual %h", f, e, a);
      mismatches++;
      return 1;
   endfunction

   initial begin
      int hold;
      step_out_type e;
      rsp_ready = 0;
      hold = 0;
      forever begin
         @(negedge clock);
         if (n_checked == 40 && hold == 0) hold = 400;
         if (hold > 1) begin
            hold--;
            rsp_ready = 0;
         end else begin
            rsp_ready = steady || $urandom_range(99) >= 36;
         end
         @(posedge clock);
         if (!reset && rsp_valid && rsp_ready) begin
            n_checked++;
            if (pending.size() == 0) begin
               if (mismatches < 10) $display("mismatch: word with nothing expected");
               mismatches++;
            end else begin
               e = pending.pop_front();
               void'(differs("new_pos_x", e.px, rsp_new_pos_x));
               void'(differs("new_pos_y", e.py, rsp_new_pos_y));
               void'(differs("new_vel_x", e.vx, rsp_new_vel_x));
               void'(differs("new_vel_y", e.vy, rsp_new_vel_y));
               void'(differs("new_life", e.life, rsp_new_life));
               void'(differs("alive", 32'(e.alive), 32'(rsp_alive)));
            end
         end
      end
   end

   initial begin
      int plan_pts[8] = '{0, 1, 3, 8, 2, 64, 127, 5};
      int plan_dt[8] = '{1092, 1, 65536, 1092, -1, -1, 1092, 131071};
      int plan_n[8] = '{300, 300, 250, 220, 150, 25, 15, 60};
      req_word_type w;
      step_out_type none;
      reset = 1;
      req_valid = 0;
      req_opcode = OP_WRITE_POINT;
      req_point_index = 0;
      {req_pos_x, req_pos_y, req_vel_x, req_vel_y, req_life_left} = '0;
      csr_we = 0;
      csr_index = CSR_ACTIVE_POINTS;
      csr_wdata = 0;
      n_active = 0;
      step_dt = 1092;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 0;

      add_word(point_word(0, 0, 0));
      add_word(point_word(1, 65536, -65536));
      for (int i = 2; i < 64; i++)
         add_word(point_word(i, $signed($urandom), $signed($urandom)));
      add_typed(particle(0, 0, 0, 0, SMAX), 0, -181, 0, -10920, SMAX - 1092, 1);
      add_typed(particle(0, 0, 0, 0, SMIN), 0, -181, 0, -10920, SMIN, 0);
      add_typed(particle(0, 0, 0, SMIN, 1092), 0, -35782656, 0, SMIN, 0, 0);
      add_typed(particle(SMAX, SMIN, SMAX, 0, 1093), SMAX, SMIN, SMAX, -10920, 1, 1);
      add_word(point_word(5, 7 << 16, -(3 << 16)));
      add_csr(CSR_ACTIVE_POINTS, 17'd2);
      add_word(particle(0, 0, 100, 100, 5000));
      add_word(particle(65537, -65536, 0, 0, 5000));
      add_word(particle(SMIN, SMIN, SMIN, SMIN, SMIN));
      add_word(particle(SMAX, SMAX, SMAX, SMAX, SMAX));
      add_csr(CSR_ACTIVE_POINTS, 17'd127);
      add_csr(CSR_TIME_STEP, 17'd0);
      add_word(particle(65536, 0, SMAX, SMIN, 0));
      add_csr(CSR_TIME_STEP, 17'd131071);
      add_word(particle(SMIN, SMAX, SMAX, SMIN, SMAX));
      add_csr(CSR_TIME_STEP, 17'd65536);
      add_csr(CSR_ACTIVE_POINTS, 17'd64);
      add_word(particle(-65536, 65536, -1, 1, 65536));
      add_csr(CSR_TIME_STEP, 17'd1);

      foreach (rows[i]) begin
         if (rows[i].is_csr) write_reg(rows[i].ci, rows[i].cv);
         else send_word(rows[i].w, rows[i].typed, rows[i].res);
      end

      for (int p = 0; p < 8; p++) begin
         write_reg(CSR_ACTIVE_POINTS, 17'(plan_pts[p]));
         write_reg(CSR_TIME_STEP, plan_dt[p] < 0 ? 17'($urandom_range(65536, 1))
                                                 : 17'(plan_dt[p]));
         steady = p == 1;
         for (int k = 0; k < plan_n[p]; k++) begin
            w = random_word();
            send_word(w, 0, none);
         end
         steady = 0;
      end

      while (pending.size() != 0) @(negedge clock);
      repeat (200) @(negedge clock);
      if (mismatches == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

@@ sim.f @@
design/pfps_pkg.sv
design/pfps_table.sv
design/particle_force_point_step.sv
dv/particle_force_point_step_test.sv
